>>> hw/rtl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg: terminal key sequence decoder shared definitions
// Parser states, key event codes, byte constants and the result record.
// ----------------------------------------------------------------------------
package tksd_pkg;

   // Parser position inside an escape sequence
   typedef enum logic [3:0] {
      ST_IDLE = 4'd0,
      ST_ESC  = 4'd1,
      ST_CSI  = 4'd2,
      ST_DEL  = 4'd3,
      ST_MOD  = 4'd4,
      ST_LAST = 4'd5,
      ST_SS3  = 4'd6,
      ST_HOME = 4'd7,
      ST_END  = 4'd8,
      ST_PAGE = 4'd9
   } state_type;

   // Key event codes
   typedef enum logic [3:0] {
      EV_CHAR  = 4'd0,
      EV_BACK  = 4'd1,
      EV_TAB   = 4'd2,
      EV_ENTER = 4'd3,
      EV_UP    = 4'd4,
      EV_DOWN  = 4'd5,
      EV_RIGHT = 4'd6,
      EV_LEFT  = 4'd7,
      EV_HOME  = 4'd8,
      EV_END   = 4'd9,
      EV_DEL   = 4'd10,
      EV_EOF   = 4'd11
   } event_type;

   // Byte values
   localparam logic [7:0] B_BS      = 8'd8;
   localparam logic [7:0] B_TAB     = 8'd9;
   localparam logic [7:0] B_LF      = 8'd10;
   localparam logic [7:0] B_CR      = 8'd13;
   localparam logic [7:0] B_ESC     = 8'd27;
   localparam logic [7:0] B_DEL     = 8'd127;
   localparam logic [7:0] B_BS_ALT  = 8'd247;
   localparam logic [7:0] B_LBRACK  = 8'h5B; // '['
   localparam logic [7:0] B_UPPER_O = 8'h4F; // 'O'
   localparam logic [7:0] B_TILDE   = 8'h7E; // '~'
   localparam logic [7:0] B_SEMI    = 8'h3B; // ';'
   localparam logic [7:0] B_DIG_1   = 8'h31;
   localparam logic [7:0] B_DIG_3   = 8'h33;
   localparam logic [7:0] B_DIG_4   = 8'h34;
   localparam logic [7:0] B_DIG_5   = 8'h35;
   localparam logic [7:0] B_DIG_6   = 8'h36;
   localparam logic [7:0] B_UPPER_A = 8'h41;
   localparam logic [7:0] B_UPPER_B = 8'h42;
   localparam logic [7:0] B_UPPER_C = 8'h43;
   localparam logic [7:0] B_UPPER_D = 8'h44;
   localparam logic [7:0] B_UPPER_F = 8'h46;
   localparam logic [7:0] B_UPPER_H = 8'h48;

   // One decoded key event
   typedef struct packed {
      logic       echo;
      event_type  code;
      logic [7:0] char_value;
   } result_type;

endpackage

>>> hw/rtl/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes raw terminal bytes and VT100/ANSI escape sequences into key events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw byte per transaction in req_tdata; req_tlast marks end of
//            input (the byte is then ignored and an eof event is produced,
//            parser position unchanged).
//   rsp_*  : zero or one key event per input transaction. rsp_tuser carries
//            the event code and echo flag, rsp_tdata the character byte.
//   csr_*  : single-bit echo enable write; always ready. Write only while
//            no events are in flight.
// Events are registered: in the result register, or in the skid entry while held.
// Throughput: one byte per cycle while req_tready is high; the parser is
//   one state register with a combinational next-state case table.
// Stall: the result register is backed by one skid entry, so a byte is still
//   taken in the cycle the receiver first stalls; req_tready drops only once
//   the skid entry is occupied, and rises again as soon as it drains.
// Reset: synchronous, active high; parser returns to idle, both output
//   entries empty, echo enable set.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder
   import tksd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_input
   // key events
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_value
   output logic [4:0] rsp_tuser,   // [3:0] event_code, [4] echo
   // echo enable register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // echo_enable
);

   state_type  state_ff,  state_in;
   logic       echo_en_ff, echo_en_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic       req_xfer;
   logic       rsp_xfer;
   logic       has_event;
   event_type  dec_code;
   state_type  dec_next;
   result_type dec_result;
   logic       push;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   // --- parser: one byte in, at most one event out ---
   always_comb begin
      has_event = 1'b0;
      dec_code  = EV_CHAR;
      dec_next  = ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tdata == B_BS || req_tdata == B_DEL || req_tdata == B_BS_ALT) begin
               has_event = 1'b1;
               dec_code  = EV_BACK;
            end else if (req_tdata == B_TAB) begin
               has_event = 1'b1;
               dec_code  = EV_TAB;
            end else if (req_tdata == B_LF || req_tdata == B_CR) begin
               has_event = 1'b1;
               dec_code  = EV_ENTER;
            end else if (req_tdata == B_ESC) begin
               dec_next = ST_ESC;
            end else begin
               has_event = 1'b1;
               dec_code  = EV_CHAR;
            end
         end
         ST_ESC: begin
            if (req_tdata == B_LBRACK)       dec_next = ST_CSI;
            else if (req_tdata == B_UPPER_O) dec_next = ST_SS3;
         end
         ST_CSI: begin
            case (req_tdata)
               B_UPPER_A: begin has_event = 1'b1; dec_code = EV_UP;    end
               B_UPPER_B: begin has_event = 1'b1; dec_code = EV_DOWN;  end
               B_UPPER_C: begin has_event = 1'b1; dec_code = EV_RIGHT; end
               B_UPPER_D: begin has_event = 1'b1; dec_code = EV_LEFT;  end
               B_UPPER_H: begin has_event = 1'b1; dec_code = EV_HOME;  end
               B_UPPER_F: begin has_event = 1'b1; dec_code = EV_END;   end
               B_DIG_3:   dec_next = ST_DEL;
               B_DIG_1:   dec_next = ST_HOME;
               B_DIG_4:   dec_next = ST_END;
               B_DIG_5:   dec_next = ST_PAGE;
               B_DIG_6:   dec_next = ST_PAGE;
               default:   dec_next = ST_IDLE;
            endcase
         end
         ST_SS3: begin
            if (req_tdata == B_UPPER_H) begin
               has_event = 1'b1;
               dec_code  = EV_HOME;
            end else if (req_tdata == B_UPPER_F) begin
               has_event = 1'b1;
               dec_code  = EV_END;
            end
         end
         ST_DEL: begin
            if (req_tdata == B_TILDE) begin
               has_event = 1'b1;
               dec_code  = EV_DEL;
            end else if (req_tdata == B_SEMI) begin
               dec_next = ST_MOD;
            end
         end
         ST_HOME: begin
            if (req_tdata == B_TILDE) begin
               has_event = 1'b1;
               dec_code  = EV_HOME;
            end else if (req_tdata == B_SEMI) begin
               dec_next = ST_MOD;
            end
         end
         ST_END: begin
            if (req_tdata == B_TILDE) begin
               has_event = 1'b1;
               dec_code  = EV_END;
            end
         end
         // page keys: only a modifier may follow, never an event
         ST_PAGE: begin
            if (req_tdata == B_SEMI) dec_next = ST_MOD;
         end
         // modifier key byte; the byte after it is swallowed in ST_LAST
         ST_MOD: begin
            if (req_tdata == B_DIG_3 || req_tdata == B_DIG_5 ||
                req_tdata == B_UPPER_A || req_tdata == B_UPPER_B ||
                req_tdata == B_UPPER_C || req_tdata == B_UPPER_D) begin
               dec_next = ST_LAST;
            end
         end
         default: begin
            dec_next = ST_IDLE;
         end
      endcase

      // end of input overrides everything and keeps the parser where it is
      if (req_tlast) begin
         has_event = 1'b1;
         dec_code  = EV_EOF;
         dec_next  = state_ff;
      end

      dec_result.code       = dec_code;
      dec_result.char_value = (dec_code == EV_CHAR) ? req_tdata : 8'd0;
      dec_result.echo       = (dec_code == EV_CHAR) ? echo_en_ff : 1'b0;
   end

   assign push = req_xfer && has_event;

   // --- output register plus one skid entry ---
   always_comb begin
      state_in      = req_xfer ? dec_next : state_ff;
      echo_en_in    = (csr_valid && csr_ready) ? csr_data : echo_en_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_xfer) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = push;
            skid_in       = dec_result;
         end else begin
            out_valid_in = push;
            out_in       = dec_result;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = dec_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = dec_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         echo_en_ff    <= 1'b1;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         echo_en_ff    <= echo_en_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.char_value;
   assign rsp_tuser  = {out_ff.echo, out_ff.code};

`ifndef NO_ASSERTIONS
   // the skid entry is only ever filled behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // end of input leaves the parser position untouched
   a_eof_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (state_ff == $past(state_ff)))
      else $error("parser state changed on end of input");

   // non-character events carry no byte and no echo
   a_non_char_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.code != EV_CHAR) |->
         (out_ff.char_value == 8'd0 && !out_ff.echo))
      else $error("non-character event with byte or echo set");

   // after an eof transaction the output register always holds an event in the next cycle
   a_eof_yields_event: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> out_valid_ff)
      else $error("end of input produced no event");
`endif

endmodule
